// File: rtl/core/handle_table_allocator_defines.svh
// assertion macros for the handle table allocator
// no dependencies; the including module must provide clk and rst_n
`ifndef HANDLE_TABLE_ALLOCATOR_DEFINES_SVH
`define HANDLE_TABLE_ALLOCATOR_DEFINES_SVH

// same-cycle implication, checked out of reset
`define HTA_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("handle table allocator check failed");

// next-cycle implication, checked out of reset
`define HTA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("handle table allocator check failed");

`endif

// File: rtl/core/hta_pkg.sv
// shared types, codes and widths of the handle table allocator
// no dependencies
package hta_pkg;

    localparam int HANDLE_W      = 32;
    localparam int OBJ_W         = 32;
    localparam int REFS_W        = 16;
    localparam int OP_W          = 2;
    localparam int STATUS_W      = 2;
    localparam int SLOTS_DEFAULT = 64;
    localparam int MOD_STEP_BITS = 4;
    localparam int MOD_STEPS     = HANDLE_W / MOD_STEP_BITS;

    localparam logic [OP_W-1:0] OP_REGISTER = 2'd0;
    localparam logic [OP_W-1:0] OP_GRAB     = 2'd1;
    localparam logic [OP_W-1:0] OP_RELEASE  = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;

    localparam logic [REFS_W-1:0] REFS_MAX = {REFS_W{1'b1}};
    localparam logic [REFS_W-1:0] REFS_ONE = REFS_W'(1);

    typedef struct packed {
        logic                used;
        logic [HANDLE_W-1:0] hdl;
        logic [OBJ_W-1:0]    obj;
        logic [REFS_W-1:0]   refs;
    } slot_entry_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_MOD,
        S_RD,
        S_CHK,
        S_PROBE_RD,
        S_PROBE_CHK,
        S_RESP
    } state_t;

endpackage

// File: rtl/core/hta_mod_unit.sv
// handle mod SLOTS: mask for a power of two, else a restoring remainder, MOD_STEP_BITS handle bits per cycle
// depends on hta_pkg
module hta_mod_unit #(
    parameter int SLOTS = hta_pkg::SLOTS_DEFAULT,
    parameter int IDX_W = $clog2(SLOTS)
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [hta_pkg::HANDLE_W-1:0] value,
    output logic                         done,
    output logic [IDX_W-1:0]             rem
);

    localparam bit IS_POW2 = (SLOTS & (SLOTS - 1)) == 0;

    generate
        if (IS_POW2) begin : g_mask
            logic             done_reg;
            logic [IDX_W-1:0] rem_reg;

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    done_reg <= 1'b0;
                end
                else
                begin
                    done_reg <= start;
                end
            end

            always_ff @(posedge clk)
            begin
                if (start)
                begin
                    rem_reg <= value[IDX_W-1:0];
                end
            end

            assign done = done_reg;
            assign rem  = rem_reg;
        end
        else begin : g_restore
            localparam int CNT_W = $clog2(hta_pkg::MOD_STEPS);
            localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(hta_pkg::MOD_STEPS - 1);
            localparam logic [IDX_W:0]   SLOTS_W   = (IDX_W + 1)'(SLOTS);

            logic                         busy_reg;
            logic                         done_reg;
            logic [CNT_W-1:0]             cnt_reg;
            logic [IDX_W-1:0]             rem_reg;
            logic [IDX_W-1:0]             rem_next;
            logic [hta_pkg::HANDLE_W-1:0] val_reg;

            // restoring remainder, msb first, one subtract per bit
            always_comb
            begin
                logic [IDX_W:0] t;
                rem_next = rem_reg;
                for (int k = 0; k < hta_pkg::MOD_STEP_BITS; k++)
                begin
                    t = {rem_next, val_reg[hta_pkg::HANDLE_W-1-k]};
                    if (t >= SLOTS_W)
                    begin
                        t = t - SLOTS_W;
                    end
                    rem_next = t[IDX_W-1:0];
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b0;
                    cnt_reg  <= '0;
                end
                else if (start)
                begin
                    busy_reg <= 1'b1;
                    done_reg <= 1'b0;
                    cnt_reg  <= '0;
                end
                else if (busy_reg)
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == LAST_STEP)
                    begin
                        busy_reg <= 1'b0;
                        done_reg <= 1'b1;
                    end
                end
                else
                begin
                    done_reg <= 1'b0;
                end
            end

            always_ff @(posedge clk)
            begin
                if (start)
                begin
                    val_reg <= value;
                    rem_reg <= '0;
                end
                else if (busy_reg)
                begin
                    val_reg <= val_reg << hta_pkg::MOD_STEP_BITS;
                    rem_reg <= rem_next;
                end
            end

            assign done = done_reg;
            assign rem  = rem_reg;
        end
    endgenerate

endmodule

// File: rtl/core/hta_slot_ram.sv
// slot table storage: a single port, one address for write and read, with registered read data
// depends on hta_pkg
module hta_slot_ram #(
    parameter int SLOTS = hta_pkg::SLOTS_DEFAULT,
    parameter int IDX_W = $clog2(SLOTS)
) (
    input  logic                  clk,
    input  logic [IDX_W-1:0]      addr,
    input  logic                  wr_en,
    input  hta_pkg::slot_entry_t  wr_data,
    output hta_pkg::slot_entry_t  rd_data
);

    hta_pkg::slot_entry_t mem [SLOTS];
    hta_pkg::slot_entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[addr] <= wr_data;
        end
        rd_data_reg <= mem[addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/core/handle_table_allocator.sv
// handle table allocator top level: sequencer, slot table and remainder unit
// depends on hta_pkg, hta_mod_unit, hta_slot_ram and the assertion macro header
//
// One input beat (operation, handle_id, object_ref) gives one output beat
// (status, handle_out, object_out, ref_count_out, slot_freed). Both channels
// are valid/ready. The block works on one beat at a time and drops in_ready
// from acceptance until the result is moved into the output register.
// Grab and release: remainder, table read, check and write back, then the
// response; when SLOTS is not a power of two the remainder unit takes 4
// handle bits per cycle. Register probes the table from the next-handle
// counter, slot by slot (read, then check), until a free slot is found or
// every slot has been probed. After reset the table is swept empty, one slot
// per cycle, with in_ready low. A result waits in the output register while
// out_ready is low; the next beat may be accepted and processed meanwhile,
// but its result holds inside until the output register is free.
`include "handle_table_allocator_defines.svh"

module handle_table_allocator #(
    parameter int SLOTS = hta_pkg::SLOTS_DEFAULT
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [hta_pkg::OP_W-1:0]     operation,
    input  logic [hta_pkg::HANDLE_W-1:0] handle_id,
    input  logic [hta_pkg::OBJ_W-1:0]    object_ref,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [hta_pkg::STATUS_W-1:0] status,
    output logic [hta_pkg::HANDLE_W-1:0] handle_out,
    output logic [hta_pkg::OBJ_W-1:0]    object_out,
    output logic [hta_pkg::REFS_W-1:0]   ref_count_out,
    output logic                         slot_freed
);

    localparam int IDX_W = $clog2(SLOTS);
    localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(SLOTS - 1);

    hta_pkg::state_t state_reg, state_next;

    logic [IDX_W-1:0]             addr_reg;
    logic [IDX_W-1:0]             probe_cnt_reg;
    logic [hta_pkg::HANDLE_W-1:0] next_handle_reg;
    logic [IDX_W-1:0]             next_slot_reg;
    logic                         out_valid_reg;

    logic [hta_pkg::OP_W-1:0]     op_reg;
    logic [hta_pkg::HANDLE_W-1:0] hid_reg;
    logic [hta_pkg::OBJ_W-1:0]    obj_reg;
    logic [hta_pkg::HANDLE_W-1:0] probe_handle_reg;

    logic [hta_pkg::STATUS_W-1:0] res_status_reg;
    logic [hta_pkg::HANDLE_W-1:0] res_handle_reg;
    logic [hta_pkg::OBJ_W-1:0]    res_obj_reg;
    logic [hta_pkg::REFS_W-1:0]   res_refs_reg;
    logic                         res_freed_reg;

    logic [hta_pkg::STATUS_W-1:0] status_reg;
    logic [hta_pkg::HANDLE_W-1:0] handle_out_reg;
    logic [hta_pkg::OBJ_W-1:0]    object_out_reg;
    logic [hta_pkg::REFS_W-1:0]   ref_count_out_reg;
    logic                         slot_freed_reg;

    logic                 mod_start;
    logic                 mod_done;
    logic [IDX_W-1:0]     mod_rem;
    logic                 wr_en;
    hta_pkg::slot_entry_t wr_data;
    hta_pkg::slot_entry_t rd_data;
    logic [IDX_W-1:0]     addr_inc;
    logic [IDX_W-1:0]     probe_addr_inc;
    logic                 resp_load;

    logic                         chk_wr;
    hta_pkg::slot_entry_t         chk_entry;
    logic [hta_pkg::STATUS_W-1:0] chk_status;
    logic [hta_pkg::OBJ_W-1:0]    chk_obj;
    logic [hta_pkg::REFS_W-1:0]   chk_refs;
    logic                         chk_freed;
    hta_pkg::slot_entry_t         probe_entry;

    hta_mod_unit #(
        .SLOTS (SLOTS),
        .IDX_W (IDX_W)
    ) u_mod (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mod_start),
        .value (handle_id),
        .done  (mod_done),
        .rem   (mod_rem)
    );

    hta_slot_ram #(
        .SLOTS (SLOTS),
        .IDX_W (IDX_W)
    ) u_ram (
        .clk     (clk),
        .addr    (addr_reg),
        .wr_en   (wr_en),
        .wr_data (wr_data),
        .rd_data (rd_data)
    );

    assign addr_inc  = (addr_reg == LAST_SLOT) ? '0 : addr_reg + 1'b1;
    // the handle after all ones is zero, which sits in slot zero for any table size
    assign probe_addr_inc = (&probe_handle_reg) ? '0 : addr_inc;
    assign resp_load = (state_reg == hta_pkg::S_RESP) && (!out_valid_reg || out_ready);

    // grab / release check on the slot just read
    always_comb
    begin
        logic                       match;
        logic [hta_pkg::REFS_W-1:0] grab_refs;
        logic [hta_pkg::REFS_W-1:0] rel_refs;
        match      = rd_data.used && (rd_data.hdl == hid_reg);
        grab_refs  = (rd_data.refs == hta_pkg::REFS_MAX) ? rd_data.refs
                                                         : rd_data.refs + 1'b1;
        rel_refs   = rd_data.refs - 1'b1;
        chk_wr     = 1'b0;
        chk_entry  = rd_data;
        chk_status = hta_pkg::ST_NOT_FOUND;
        chk_obj    = '0;
        chk_refs   = '0;
        chk_freed  = 1'b0;
        if (match && op_reg == hta_pkg::OP_GRAB)
        begin
            chk_wr         = 1'b1;
            chk_entry.refs = grab_refs;
            chk_status     = hta_pkg::ST_OK;
            chk_obj        = rd_data.obj;
            chk_refs       = grab_refs;
        end
        else if (match && op_reg == hta_pkg::OP_RELEASE)
        begin
            chk_wr     = 1'b1;
            chk_status = hta_pkg::ST_OK;
            chk_obj    = rd_data.obj;
            // a count of zero or one frees the slot
            if (rd_data.refs <= hta_pkg::REFS_ONE)
            begin
                chk_entry.used = 1'b0;
                chk_entry.refs = '0;
                chk_freed      = 1'b1;
            end
            else
            begin
                chk_entry.refs = rel_refs;
                chk_refs       = rel_refs;
            end
        end
    end

    always_comb
    begin
        probe_entry.used = 1'b1;
        probe_entry.hdl  = probe_handle_reg;
        probe_entry.obj  = obj_reg;
        probe_entry.refs = hta_pkg::REFS_ONE;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            hta_pkg::S_CLEAR:
            begin
                if (addr_reg == LAST_SLOT)
                begin
                    state_next = hta_pkg::S_IDLE;
                end
            end
            hta_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = (operation == hta_pkg::OP_REGISTER) ? hta_pkg::S_PROBE_RD
                                                                     : hta_pkg::S_MOD;
                end
            end
            hta_pkg::S_MOD:
            begin
                if (mod_done)
                begin
                    state_next = hta_pkg::S_RD;
                end
            end
            hta_pkg::S_RD:       state_next = hta_pkg::S_CHK;
            hta_pkg::S_CHK:      state_next = hta_pkg::S_RESP;
            hta_pkg::S_PROBE_RD: state_next = hta_pkg::S_PROBE_CHK;
            hta_pkg::S_PROBE_CHK:
            begin
                if (!rd_data.used || probe_cnt_reg == LAST_SLOT)
                begin
                    state_next = hta_pkg::S_RESP;
                end
                else
                begin
                    state_next = hta_pkg::S_PROBE_RD;
                end
            end
            hta_pkg::S_RESP:
            begin
                if (resp_load)
                begin
                    state_next = hta_pkg::S_IDLE;
                end
            end
            default: state_next = hta_pkg::S_CLEAR;
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        in_ready  = 1'b0;
        mod_start = 1'b0;
        wr_en     = 1'b0;
        wr_data   = '0;
        case (state_reg)
            hta_pkg::S_CLEAR:
            begin
                wr_en = 1'b1;
            end
            hta_pkg::S_IDLE:
            begin
                in_ready  = 1'b1;
                mod_start = in_valid && (operation != hta_pkg::OP_REGISTER);
            end
            hta_pkg::S_CHK:
            begin
                wr_en   = chk_wr;
                wr_data = chk_entry;
            end
            hta_pkg::S_PROBE_CHK:
            begin
                wr_en   = !rd_data.used;
                wr_data = probe_entry;
            end
            default:
            begin
                wr_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= hta_pkg::S_CLEAR;
            addr_reg        <= '0;
            probe_cnt_reg   <= '0;
            next_handle_reg <= '0;
            next_slot_reg   <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            case (state_reg)
                hta_pkg::S_CLEAR:
                begin
                    addr_reg <= addr_inc;
                end
                hta_pkg::S_IDLE:
                begin
                    if (in_valid && operation == hta_pkg::OP_REGISTER)
                    begin
                        addr_reg      <= next_slot_reg;
                        probe_cnt_reg <= '0;
                    end
                end
                hta_pkg::S_MOD:
                begin
                    if (mod_done)
                    begin
                        addr_reg <= mod_rem;
                    end
                end
                hta_pkg::S_PROBE_CHK:
                begin
                    if (!rd_data.used)
                    begin
                        next_handle_reg <= probe_handle_reg + 1'b1;
                        next_slot_reg   <= probe_addr_inc;
                    end
                    else if (probe_cnt_reg != LAST_SLOT)
                    begin
                        addr_reg      <= probe_addr_inc;
                        probe_cnt_reg <= probe_cnt_reg + 1'b1;
                    end
                end
                default:
                begin
                    addr_reg <= addr_reg;
                end
            endcase
            if (resp_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == hta_pkg::S_IDLE && in_valid)
        begin
            op_reg           <= operation;
            hid_reg          <= handle_id;
            obj_reg          <= object_ref;
            probe_handle_reg <= next_handle_reg;
        end
        if (state_reg == hta_pkg::S_CHK)
        begin
            res_status_reg <= chk_status;
            res_handle_reg <= hid_reg;
            res_obj_reg    <= chk_obj;
            res_refs_reg   <= chk_refs;
            res_freed_reg  <= chk_freed;
        end
        if (state_reg == hta_pkg::S_PROBE_CHK)
        begin
            probe_handle_reg <= probe_handle_reg + 1'b1;
            res_freed_reg    <= 1'b0;
            if (!rd_data.used)
            begin
                res_status_reg <= hta_pkg::ST_OK;
                res_handle_reg <= probe_handle_reg;
                res_obj_reg    <= obj_reg;
                res_refs_reg   <= hta_pkg::REFS_ONE;
            end
            else
            begin
                res_status_reg <= hta_pkg::ST_FULL;
                res_handle_reg <= '0;
                res_obj_reg    <= '0;
                res_refs_reg   <= '0;
            end
        end
        if (resp_load)
        begin
            status_reg        <= res_status_reg;
            handle_out_reg    <= res_handle_reg;
            object_out_reg    <= res_obj_reg;
            ref_count_out_reg <= res_refs_reg;
            slot_freed_reg    <= res_freed_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign status        = status_reg;
    assign handle_out    = handle_out_reg;
    assign object_out    = object_out_reg;
    assign ref_count_out = ref_count_out_reg;
    assign slot_freed    = slot_freed_reg;

    `HTA_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)
    `HTA_ASSERT_NOW(a_full_zero_fields, out_valid && status == hta_pkg::ST_FULL,
                    handle_out == '0 && object_out == '0 && ref_count_out == '0)
    `HTA_ASSERT_NOW(a_freed_is_ok, out_valid && slot_freed,
                    status == hta_pkg::ST_OK && ref_count_out == '0)
    `HTA_ASSERT_NOW(a_addr_in_table, state_reg != hta_pkg::S_CLEAR, addr_reg <= LAST_SLOT)

endmodule
